@@ rtl/spcf_pkg.sv @@
// ----------------------------------------------------------------------------
// spcf_pkg
// Shared types and constants for the sphere pair contact friction block.
// ----------------------------------------------------------------------------
package spcf_pkg;

    typedef enum logic [1:0] {
        FM_NONE    = 2'd0,
        FM_STATIC  = 2'd1,
        FM_KINETIC = 2'd2
    } t_fmode;

    localparam logic [1:0] CFG_STIFF  = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_SFRIC  = 2'd2;
    localparam logic [1:0] CFG_KFRIC  = 2'd3;

    localparam logic [16:0] STIFF_RST  = 17'd65536;
    localparam logic [30:0] RADIUS_RST = 31'd66847;
    localparam logic [16:0] SFRIC_RST  = 17'd0;
    localparam logic [16:0] KFRIC_RST  = 17'd0;

    localparam logic [16:0] Q_ONE = 17'd65536;

endpackage

@@ rtl/spcf_sqrt.sv @@
// ----------------------------------------------------------------------------
// spcf_sqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module spcf_sqrt #(
    parameter int unsigned IW = 64,
    parameter int unsigned SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IW-1:0]     i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [IW/2-1:0]   o_root,
    output logic [SW-1:0]     o_side
);
    localparam int unsigned RW = IW / 2;
    localparam int unsigned CW = IW + 2;

    logic [RW-1:0] r_v;
    logic [CW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] r_side [RW];

    logic [CW-1:0] rem_in  [RW];
    logic [CW-1:0] trial   [RW];
    logic [CW-1:0] n_rem   [RW];
    logic [RW-1:0] root_in [RW];
    logic [RW-1:0] n_root  [RW];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                rem_in[k]  = CW'(i_rad);
                root_in[k] = '0;
            end else begin
                rem_in[k]  = r_rem[k-1];
                root_in[k] = r_root[k-1];
            end
            trial[k] = (CW'(root_in[k]) << (RW - k)) + (CW'(1) << (2 * (RW - 1 - k)));
            if (rem_in[k] >= trial[k]) begin
                n_rem[k]  = rem_in[k] - trial[k];
                n_root[k] = root_in[k] | (RW'(1) << (RW - 1 - k));
            end else begin
                n_rem[k]  = rem_in[k];
                n_root[k] = root_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                if (k == 0) begin
                    r_side[k] <= i_side;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

@@ rtl/spcf_div.sv @@
// ----------------------------------------------------------------------------
// spcf_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor,
// several lanes and sideband. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module spcf_div #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 32,
    parameter int unsigned QW = 16,
    parameter int unsigned LN = 1,
    parameter int unsigned SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [LN-1:0][NW-1:0]  i_num,
    input  logic [DW-1:0]          i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [LN-1:0][QW-1:0]  o_quo,
    output logic [SW-1:0]          o_side
);
    localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW-1:0] r_v;
    logic [CW-1:0] r_rem  [QW][LN];
    logic [QW-1:0] r_quo  [QW][LN];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    logic [CW-1:0] rem_in [QW][LN];
    logic [QW-1:0] quo_in [QW][LN];
    logic [CW-1:0] n_rem  [QW][LN];
    logic [QW-1:0] n_quo  [QW][LN];
    logic [DW-1:0] den_in [QW];
    logic [CW-1:0] trial  [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            den_in[k] = (k == 0) ? i_den : r_den[k-1];
            trial[k]  = CW'(den_in[k]) << (QW - 1 - k);
            for (int l = 0; l < LN; l++) begin
                if (k == 0) begin
                    rem_in[k][l] = CW'(i_num[l]);
                    quo_in[k][l] = '0;
                end else begin
                    rem_in[k][l] = r_rem[k-1][l];
                    quo_in[k][l] = r_quo[k-1][l];
                end
                if (rem_in[k][l] >= trial[k]) begin
                    n_rem[k][l] = rem_in[k][l] - trial[k];
                    n_quo[k][l] = quo_in[k][l] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_rem[k][l] = rem_in[k][l];
                    n_quo[k][l] = quo_in[k][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_den[k]  <= den_in[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
                for (int l = 0; l < LN; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_quo[k][l] <= n_quo[k][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            o_quo[l] = r_quo[QW-1][l];
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

@@ rtl/sphere_pair_contact_friction.sv @@
// ----------------------------------------------------------------------------
// sphere_pair_contact_friction
// Sphere pair contact push and friction correction, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the pipe advances; the two 32-stage square
// roots and the 17- and 16-stage dividers are fully pipelined, one bit per stage.
// The whole pipe advances when the output register is empty or taken.
// Reset: synchronous, active low; clears valid bits and sets the configuration registers.
module sphere_pair_contact_friction (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_a_x/y/z, prev_a_x/y/z, pos_b_x/y/z, prev_b_x/y/z, 32 bits each
    input  logic [383:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // delta_x, delta_y, delta_z, 32 bits each
    output logic [95:0]   m_axis_tdata,
    // in_contact, friction_mode[1:0]
    output logic [2:0]    m_axis_tuser
);
    import spcf_pkg::*;

    typedef struct packed {
        logic             c;
        logic [2:0]       dneg;
        logic [2:0][30:0] dmag;
        logic [2:0][34:0] slip;
    } t_sa_side;

    typedef struct packed {
        logic             c;
        logic             dz;
        logic [2:0]       dneg;
        logic [2:0][34:0] slip;
        logic [30:0]      pen;
    } t_sb_side;

    typedef struct packed {
        logic             c;
        logic [30:0]      pen;
        logic [3:0]       s;
        logic [2:0][32:0] dp;
        logic [2:0][38:0] tm;
        logic [2:0]       tneg;
    } t_sc_side;

    typedef struct packed {
        logic             c;
        t_fmode           mode;
        logic             useq;
        logic [2:0][32:0] dp;
        logic [2:0][38:0] tm;
        logic [2:0]       tneg;
    } t_sd_side;

    localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
    localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

    logic [16:0] r_stiff;
    logic [30:0] r_radius;
    logic [16:0] r_sfric;
    logic [16:0] r_kfric;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff  <= STIFF_RST;
            r_radius <= RADIUS_RST;
            r_sfric  <= SFRIC_RST;
            r_kfric  <= KFRIC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STIFF:  r_stiff  <= i_cfg_data[16:0];
                CFG_RADIUS: r_radius <= i_cfg_data;
                CFG_SFRIC:  r_sfric  <= i_cfg_data[16:0];
                CFG_KFRIC:  r_kfric  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // stage 1: differences and per-axis reject
    logic signed [32:0] d_in   [3];
    logic signed [34:0] slip_in[3];
    logic        [32:0] dm_in  [3];
    t_sa_side           n1_sd;
    logic               r1_v;
    t_sa_side           r1_sd;

    always_comb begin
        n1_sd.c = 1'b1;
        for (int i = 0; i < 3; i++) begin
            d_in[i] = 33'($signed(s_axis_tdata[32*(6+i) +: 32]))
                    - 33'($signed(s_axis_tdata[32*i +: 32]));
            slip_in[i] = (35'($signed(s_axis_tdata[32*i +: 32]))
                        - 35'($signed(s_axis_tdata[32*(3+i) +: 32])))
                       - (35'($signed(s_axis_tdata[32*(6+i) +: 32]))
                        - 35'($signed(s_axis_tdata[32*(9+i) +: 32])));
            dm_in[i] = d_in[i][32] ? $unsigned(-d_in[i]) : $unsigned(d_in[i]);
            if (dm_in[i] >= 33'(r_radius)) begin
                n1_sd.c = 1'b0;
            end
            n1_sd.dneg[i] = d_in[i][32];
            n1_sd.dmag[i] = dm_in[i][30:0];
            n1_sd.slip[i] = slip_in[i];
        end
    end

    // stage 2: squares
    logic        r2_v;
    t_sa_side    r2_sd;
    logic [61:0] r2_sq [3];
    logic [61:0] r2_rr;

    // stage 3: sum and distance reject
    logic        r3_v;
    t_sa_side    r3_sd;
    logic [63:0] r3_sum;
    logic [63:0] sum3;

    assign sum3 = 64'(r2_sq[0]) + 64'(r2_sq[1]) + 64'(r2_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sd <= n1_sd;
            r2_sd <= r1_sd;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 62'(r1_sd.dmag[i]) * 62'(r1_sd.dmag[i]);
            end
            r2_rr  <= 62'(r_radius) * 62'(r_radius);
            r3_sd  <= {r2_sd.c & (sum3 < 64'(r2_rr)), r2_sd.dneg, r2_sd.dmag, r2_sd.slip};
            r3_sum <= sum3;
        end
    end

    // distance root
    logic        sa_v;
    logic [31:0] sa_root;
    t_sa_side    sa_sd;

    spcf_sqrt #(.IW(64), .SW($bits(t_sa_side))) u_sqrt_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rad   (r3_sum),
        .i_side  (r3_sd),
        .o_valid (sa_v),
        .o_root  (sa_root),
        .o_side  (sa_sd)
    );

    // stage 4: penetration, normal division setup
    logic             r4_v;
    logic [2:0][46:0] r4_num;
    logic [30:0]      r4_den;
    t_sb_side         r4_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= sa_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= {sa_sd.dmag[i], 16'b0};
            end
            r4_den     <= sa_root[30:0];
            r4_sd.c    <= sa_sd.c;
            r4_sd.dz   <= (sa_root == '0);
            r4_sd.dneg <= sa_sd.dneg;
            r4_sd.slip <= sa_sd.slip;
            r4_sd.pen  <= r_radius - sa_root[30:0];
        end
    end

    logic             nb_v;
    logic [2:0][16:0] nb_q;
    t_sb_side         nb_sd;

    spcf_div #(.NW(47), .DW(31), .QW(17), .LN(3), .SW($bits(t_sb_side))) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_sd),
        .o_valid (nb_v),
        .o_quo   (nb_q),
        .o_side  (nb_sd)
    );

    // stages 5..14: push, slip, tangent, tangent squares
    logic signed [17:0] n5 [3];

    logic               r5_v,  r6_v,  r7_v,  r8_v,  r9_v;
    logic               r10_v, r11_v, r12_v, r13_v, r14_v;
    logic               r5_c,  r6_c,  r7_c,  r8_c,  r9_c;
    logic               r10_c, r11_c, r12_c, r13_c, r14_c;
    logic        [30:0] r5_pen, r6_pen, r7_pen, r8_pen, r9_pen;
    logic        [30:0] r10_pen, r11_pen, r12_pen, r13_pen, r14_pen;
    logic signed [34:0] r5_slip [3];
    logic signed [34:0] r6_slip [3];
    logic signed [17:0] r5_n [3];
    logic signed [17:0] r6_n [3];
    logic signed [17:0] r7_n [3];
    logic signed [17:0] r8_n [3];
    logic signed [17:0] r9_n [3];
    logic        [47:0] r5_pm [3];
    logic        [48:0] r6_am [3];
    logic signed [32:0] r7_dp [3];
    logic signed [32:0] r8_dp [3];
    logic signed [32:0] r9_dp [3];
    logic signed [32:0] r10_dp [3];
    logic signed [32:0] r11_dp [3];
    logic signed [32:0] r12_dp [3];
    logic signed [32:0] r13_dp [3];
    logic signed [32:0] r14_dp [3];
    logic signed [35:0] r7_t1 [3];
    logic signed [35:0] r8_t1 [3];
    logic signed [35:0] r9_t1 [3];
    logic signed [35:0] r10_t1 [3];
    logic signed [53:0] r8_tn [3];
    logic signed [40:0] r9_dot;
    logic signed [58:0] r10_dn [3];
    logic signed [39:0] r11_t2 [3];
    logic        [38:0] r12_tm [3];
    logic        [38:0] r13_tm [3];
    logic        [38:0] r14_tm [3];
    logic        [2:0]  r12_tneg, r13_tneg, r14_tneg;
    logic        [30:0] r12_sh [3];
    logic        [3:0]  r12_s, r13_s, r14_s;
    logic        [61:0] r13_sq [3];
    logic        [63:0] r14_tsum;

    logic        [31:0] dpm7 [3];
    logic signed [32:0] dp7 [3];
    logic signed [55:0] dsum9;
    logic        [55:0] dmag9;
    logic        [39:0] dq9;
    logic        [58:0] cmag11 [3];
    logic signed [39:0] corr11 [3];
    logic        [39:0] tm12 [3];
    logic        [38:0] maxm12;
    logic        [3:0]  s12;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5[i] = nb_sd.dneg[i] ? $signed({1'b0, (nb_sd.dz ? 17'd0 : nb_q[i])})
                                  : -$signed({1'b0, (nb_sd.dz ? 17'd0 : nb_q[i])});
            dpm7[i] = r6_am[i][48:17];
            dp7[i]  = r6_n[i][17] ? -$signed({1'b0, dpm7[i]}) : $signed({1'b0, dpm7[i]});
            cmag11[i] = r10_dn[i][58] ? $unsigned(-r10_dn[i]) : $unsigned(r10_dn[i]);
            corr11[i] = r10_dn[i][58] ? -$signed(40'(cmag11[i] >> 16))
                                      : $signed(40'(cmag11[i] >> 16));
            tm12[i] = r11_t2[i][39] ? $unsigned(-r11_t2[i]) : $unsigned(r11_t2[i]);
        end
        dsum9 = 56'(r8_tn[0]) + 56'(r8_tn[1]) + 56'(r8_tn[2]);
        dmag9 = dsum9[55] ? $unsigned(-dsum9) : $unsigned(dsum9);
        dq9   = dmag9[55:16];
        maxm12 = tm12[0][38:0];
        if (tm12[1][38:0] > maxm12) maxm12 = tm12[1][38:0];
        if (tm12[2][38:0] > maxm12) maxm12 = tm12[2][38:0];
        s12 = 4'd0;
        for (int j = 31; j < 39; j++) begin
            if (maxm12[j]) s12 = 4'(j - 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v  <= 1'b0; r6_v  <= 1'b0; r7_v  <= 1'b0; r8_v  <= 1'b0; r9_v  <= 1'b0;
            r10_v <= 1'b0; r11_v <= 1'b0; r12_v <= 1'b0; r13_v <= 1'b0; r14_v <= 1'b0;
        end else if (en) begin
            r5_v  <= nb_v;  r6_v  <= r5_v;  r7_v  <= r6_v;  r8_v  <= r7_v;
            r9_v  <= r8_v;  r10_v <= r9_v;  r11_v <= r10_v; r12_v <= r11_v;
            r13_v <= r12_v; r14_v <= r13_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_c  <= nb_sd.c; r6_c  <= r5_c;  r7_c  <= r6_c;  r8_c  <= r7_c;
            r9_c  <= r8_c;    r10_c <= r9_c;  r11_c <= r10_c; r12_c <= r11_c;
            r13_c <= r12_c;   r14_c <= r13_c;
            r5_pen  <= nb_sd.pen; r6_pen  <= r5_pen;  r7_pen  <= r6_pen;
            r8_pen  <= r7_pen;    r9_pen  <= r8_pen;  r10_pen <= r9_pen;
            r11_pen <= r10_pen;   r12_pen <= r11_pen; r13_pen <= r12_pen;
            r14_pen <= r13_pen;
            for (int i = 0; i < 3; i++) begin
                r5_slip[i] <= $signed(nb_sd.slip[i]);
                r5_n[i]    <= n5[i];
                r5_pm[i]   <= 48'(nb_sd.pen) * 48'(nb_sd.dz ? 17'd0 : nb_q[i]);
                r6_slip[i] <= r5_slip[i];
                r6_n[i]    <= r5_n[i];
                r6_am[i]   <= 49'(r5_pm[i][47:16]) * 49'(r_stiff);
                r7_n[i]    <= r6_n[i];
                r7_dp[i]   <= dp7[i];
                r7_t1[i]   <= 36'(r6_slip[i]) + 36'(dp7[i]) + 36'(dp7[i]);
                r8_n[i]    <= r7_n[i];
                r8_dp[i]   <= r7_dp[i];
                r8_t1[i]   <= r7_t1[i];
                r8_tn[i]   <= r7_t1[i] * r7_n[i];
                r9_n[i]    <= r8_n[i];
                r9_dp[i]   <= r8_dp[i];
                r9_t1[i]   <= r8_t1[i];
                r10_dp[i]  <= r9_dp[i];
                r10_t1[i]  <= r9_t1[i];
                r10_dn[i]  <= r9_dot * r9_n[i];
                r11_dp[i]  <= r10_dp[i];
                r11_t2[i]  <= 40'(r10_t1[i]) - corr11[i];
                r12_dp[i]  <= r11_dp[i];
                r12_tm[i]  <= tm12[i][38:0];
                r12_sh[i]  <= 31'(tm12[i][38:0] >> s12);
                r13_dp[i]  <= r12_dp[i];
                r13_tm[i]  <= r12_tm[i];
                r13_sq[i]  <= 62'(r12_sh[i]) * 62'(r12_sh[i]);
                r14_dp[i]  <= r13_dp[i];
                r14_tm[i]  <= r13_tm[i];
            end
            r9_dot   <= dsum9[55] ? -$signed({1'b0, dq9}) : $signed({1'b0, dq9});
            r12_tneg <= {r11_t2[2][39], r11_t2[1][39], r11_t2[0][39]};
            r13_tneg <= r12_tneg;
            r14_tneg <= r13_tneg;
            r12_s    <= s12;
            r13_s    <= r12_s;
            r14_s    <= r13_s;
            r14_tsum <= 64'(r13_sq[0]) + 64'(r13_sq[1]) + 64'(r13_sq[2]);
        end
    end

    t_sc_side sc_in;

    always_comb begin
        sc_in.c    = r14_c;
        sc_in.pen  = r14_pen;
        sc_in.s    = r14_s;
        sc_in.tneg = r14_tneg;
        for (int i = 0; i < 3; i++) begin
            sc_in.dp[i] = r14_dp[i];
            sc_in.tm[i] = r14_tm[i];
        end
    end

    logic        sb_v;
    logic [31:0] sb_root;
    t_sc_side    sb_sd;

    spcf_sqrt #(.IW(64), .SW($bits(t_sc_side))) u_sqrt_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r14_v),
        .i_rad   (r14_tsum),
        .i_side  (sc_in),
        .o_valid (sb_v),
        .o_root  (sb_root),
        .o_side  (sb_sd)
    );

    // stages 15..16: tangent length, friction thresholds
    logic        r15_v, r16_v;
    t_sc_side    r15_sd;
    logic [39:0] r15_tlen;
    logic [47:0] r15_sp;
    logic [47:0] r15_kp;
    logic [47:0] r16_kp;
    logic [39:0] r16_tlen;
    t_sd_side    r16_sd;

    logic [55:0] tl16;
    logic        stat16;
    logic        kcl16;
    t_fmode      mode16;

    always_comb begin
        tl16   = {r15_tlen, 16'b0};
        stat16 = tl16 < 56'(r15_sp);
        kcl16  = tl16 <= 56'(r15_kp);
        if (r15_tlen == '0) begin
            mode16 = FM_NONE;
        end else if (stat16) begin
            mode16 = FM_STATIC;
        end else begin
            mode16 = FM_KINETIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r15_v <= 1'b0;
            r16_v <= 1'b0;
        end else if (en) begin
            r15_v <= sb_v;
            r16_v <= r15_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r15_sd      <= sb_sd;
            r15_tlen    <= 40'(sb_root) << sb_sd.s;
            r15_sp      <= 48'(r_sfric) * 48'(sb_sd.pen);
            r15_kp      <= 48'(r_kfric) * 48'(sb_sd.pen);
            r16_kp      <= r15_kp;
            r16_tlen    <= r15_tlen;
            r16_sd.c    <= r15_sd.c;
            r16_sd.mode <= mode16;
            r16_sd.useq <= (mode16 == FM_KINETIC) && !kcl16;
            r16_sd.dp   <= r15_sd.dp;
            r16_sd.tm   <= r15_sd.tm;
            r16_sd.tneg <= r15_sd.tneg;
        end
    end

    logic             kd_v;
    logic [0:0][15:0] kd_q;
    t_sd_side         kd_sd;

    spcf_div #(.NW(48), .DW(40), .QW(16), .LN(1), .SW($bits(t_sd_side))) u_div_kin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r16_v),
        .i_num   (r16_kp),
        .i_den   (r16_tlen),
        .i_side  (r16_sd),
        .o_valid (kd_v),
        .o_quo   (kd_q),
        .o_side  (kd_sd)
    );

    // stages 17..19: friction scale, stiffness, output
    logic        r17_v, r18_v, r19_v;
    t_sd_side    r17_sd, r18_sd;
    logic [55:0] r17_tk [3];
    logic [56:0] r18_us [3];
    logic [16:0] k17;

    logic [95:0] r19_data;
    logic [2:0]  r19_user;

    logic [39:0]        fm19 [3];
    logic signed [41:0] f19  [3];
    logic signed [41:0] dl19 [3];
    logic [95:0]        n19_data;
    logic [2:0]         n19_user;

    assign k17 = kd_sd.useq ? {1'b0, kd_q[0]} : Q_ONE;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fm19[i] = r18_us[i][56:17];
            if (r18_sd.mode == FM_NONE) begin
                f19[i] = '0;
            end else if (r18_sd.tneg[i]) begin
                f19[i] = -$signed({2'b0, fm19[i]});
            end else begin
                f19[i] = $signed({2'b0, fm19[i]});
            end
            dl19[i] = 42'($signed(r18_sd.dp[i])) - f19[i];
            if (!r18_sd.c) begin
                n19_data[32*i +: 32] = '0;
            end else if (dl19[i] > SAT_HI) begin
                n19_data[32*i +: 32] = 32'h7FFF_FFFF;
            end else if (dl19[i] < SAT_LO) begin
                n19_data[32*i +: 32] = 32'h8000_0000;
            end else begin
                n19_data[32*i +: 32] = dl19[i][31:0];
            end
        end
        n19_user = r18_sd.c ? {r18_sd.mode, 1'b1} : {FM_NONE, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r17_v <= 1'b0;
            r18_v <= 1'b0;
            r19_v <= 1'b0;
        end else if (en) begin
            r17_v <= kd_v;
            r18_v <= r17_v;
            r19_v <= r18_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r17_sd <= kd_sd;
            r18_sd <= r17_sd;
            for (int i = 0; i < 3; i++) begin
                r17_tk[i] <= 56'(kd_sd.tm[i]) * 56'(k17);
                r18_us[i] <= 57'(r17_tk[i][55:16]) * 57'(r_stiff);
            end
            r19_data <= n19_data;
            r19_user <= n19_user;
        end
    end

    assign en            = !r19_v || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r19_v;
    assign m_axis_tdata  = r19_data;
    assign m_axis_tuser  = r19_user;

    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tuser[2:1] == FM_NONE)
        else $error("non-contact beat carries a correction");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r1_v)
        else $error("accepted beat missing from first stage");

    a_quotient_kinetic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r16_v && r16_sd.useq |-> r16_sd.mode == FM_KINETIC)
        else $error("friction quotient selected outside kinetic mode");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sphere_pair_contact_friction. A directed table of
// sphere pairs is followed by random pairs, mostly overlapping with random
// slip, under several register settings. Every output beat is compared in order,
// field by field, with the directed row's expectation or a Q16.16 contact and friction predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spcf_pkg::*;

    localparam int LATENCY = 116;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [11:0][31:0] t_pair;

    typedef struct {
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] dz;
        logic        contact;
        t_fmode      mode;
    } t_corr;

    typedef struct {
        bit    known;
        t_corr corr;
    } t_pending;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [30:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    sphere_pair_contact_friction dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    longint   reg_stiff = 65536;
    longint   reg_radius = 66847;
    longint   reg_sfric = 0;
    longint   reg_kfric = 0;
    t_corr    corr_q[$];
    t_pending pending_q[$];
    t_pending dir_q[$];
    t_pair    dir_pairs[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       quiet = 1'b0;
    bit       hold = 1'b0;
    bit       hold_go = 1'b0;

    function automatic longint unsigned isqrt_u64(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic logic [31:0] sat_q16(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_corr predict_contact(t_pair p);
        longint pa[3], xa[3], pb[3], xb[3], d[3], n[3], dp[3], t[3], f[3];
        longint unsigned sum, clen, tlen, maxm, tsum, m;
        longint pen, dot, k;
        int s;
        t_corr c;
        sum = 0; maxm = 0; tsum = 0; dot = 0; s = 0;
        c = '{32'd0, 32'd0, 32'd0, 1'b0, FM_NONE};
        for (int i = 0; i < 3; i++) begin
            pa[i] = longint'($signed(p[i]));
            xa[i] = longint'($signed(p[3+i]));
            pb[i] = longint'($signed(p[6+i]));
            xb[i] = longint'($signed(p[9+i]));
            d[i]  = pb[i] - pa[i];
            if (magn(d[i]) >= longint'(reg_radius)) return c;
        end
        for (int i = 0; i < 3; i++) sum += longint'(d[i] * d[i]);
        if (sum >= longint'(reg_radius * reg_radius)) return c;
        clen = isqrt_u64(sum);
        pen = reg_radius - longint'(clen);
        for (int i = 0; i < 3; i++) begin
            n[i]  = (clen != 0) ? (-d[i] * 65536) / longint'(clen) : 0;
            dp[i] = ((pen * n[i]) / 65536) * reg_stiff / 131072;
        end
        for (int i = 0; i < 3; i++) begin
            t[i] = (pa[i] - xa[i]) - (pb[i] - xb[i]) + 2 * dp[i];
            dot += t[i] * n[i];
        end
        dot /= 65536;
        for (int i = 0; i < 3; i++) begin
            t[i] -= (dot * n[i]) / 65536;
            if (magn(t[i]) > maxm) maxm = magn(t[i]);
            f[i] = 0;
        end
        while ((maxm >> s) >= (64'd1 << 31)) s++;
        for (int i = 0; i < 3; i++) begin
            m = magn(t[i]) >> s;
            tsum += m * m;
        end
        tlen = isqrt_u64(tsum) << s;
        if (tlen != 0) begin
            if (longint'(tlen) * 65536 < reg_sfric * pen) begin
                c.mode = FM_STATIC;
                for (int i = 0; i < 3; i++) f[i] = t[i] * reg_stiff / 131072;
            end else begin
                k = (reg_kfric * pen) / longint'(tlen);
                if (k > 65536) k = 65536;
                c.mode = FM_KINETIC;
                for (int i = 0; i < 3; i++)
                    f[i] = ((t[i] * k) / 65536) * reg_stiff / 131072;
            end
        end
        c.dx = sat_q16(dp[0] - f[0]);
        c.dy = sat_q16(dp[1] - f[1]);
        c.dz = sat_q16(dp[2] - f[2]);
        c.contact = 1'b1;
        return c;
    endfunction

    // signed value in [-span, span]
    function automatic longint rnd_span(longint span);
        longint unsigned u;
        u = {$urandom(), $urandom()};
        return longint'(u % longint'(2 * span + 1)) - span;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        longint off, vel, sel;
        if ($urandom_range(99) < 30) begin
            for (int i = 0; i < 12; i++) p[i] = $urandom();
            return p;
        end
        sel = $urandom_range(9);
        off = (sel < 8) ? reg_radius / 2 : reg_radius;
        case ($urandom_range(3))
            0: vel = 0;
            1: vel = reg_radius / 64 + 1;
            2: vel = reg_radius / 8 + 1;
            default: vel = reg_radius;
        endcase
        for (int i = 0; i < 3; i++) begin
            p[i]   = $urandom();
            p[6+i] = p[i] + 32'(rnd_span(off));
            p[3+i] = p[i] - 32'(rnd_span(vel));
            p[9+i] = p[6+i] - 32'(rnd_span(vel));
        end
        return p;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STIFF:  reg_stiff  = longint'(val[16:0]);
            CFG_RADIUS: reg_radius = longint'(val);
            CFG_SFRIC:  reg_sfric  = longint'(val[16:0]);
            CFG_KFRIC:  reg_kfric  = longint'(val[16:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (corr_q.size() == 0 && pending_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic send_pair(t_pair p, t_pending pend);
        while (!quiet && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pending_q.insert(pending_q.size(), pend);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic add_row(bit known, bit ec, logic [95:0] pa, logic [95:0] xa,
                           logic [95:0] pb, logic [95:0] xb);
        t_pending r;
        r.known = known;
        r.corr  = '{32'd0, 32'd0, 32'd0, ec, FM_NONE};
        dir_q.insert(dir_q.size(), r);
        dir_pairs.insert(dir_pairs.size(), {xb, pb, xa, pa});
    endtask

    task automatic random_phase(int count, longint stiff, longint radius,
                                longint sf, longint kf);
        t_pending pr;
        drain();
        cfg_write(CFG_STIFF, 31'(stiff));
        cfg_write(CFG_RADIUS, 31'(radius));
        cfg_write(CFG_SFRIC, 31'(sf));
        cfg_write(CFG_KFRIC, 31'(kf));
        pr.known = 1'b0;
        pr.corr  = '{32'd0, 32'd0, 32'd0, 1'b0, FM_NONE};
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && radius == 2147483647) begin
                drain();
            end
            send_pair(random_pair(), pr);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    initial begin
        wait (hold_go);
        hold = 1'b1;
        repeat (400) @(posedge i_clk);
        hold = 1'b0;
    end

    always @(posedge i_clk) begin
        t_pending pe;
        t_corr    want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pe = pending_q.pop_front();
            corr_q.insert(corr_q.size(),
                          pe.known ? pe.corr : predict_contact(s_axis_tdata));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (corr_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected beat %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = corr_q.pop_front();
                if (m_axis_tdata[31:0] !== want.dx || m_axis_tdata[63:32] !== want.dy ||
                    m_axis_tdata[95:64] !== want.dz || m_axis_tuser[0] !== want.contact ||
                    m_axis_tuser[2:1] !== want.mode) begin
                    if (mismatches < 10)
                        $display("mismatch: exp %h %h %h c%b m%0d got %h %h %h c%b m%0d",
                                 want.dx, want.dy, want.dz, want.contact, want.mode,
                                 m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[95:64], m_axis_tuser[0], m_axis_tuser[2:1]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        localparam logic [95:0] Z3 = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: radius just over one, no friction
        add_row(1, 0, Z3, Z3, {32'd0, 32'd0, 32'h0010_0000}, Z3);
        add_row(1, 1, Z3, Z3, Z3, Z3);
        add_row(1, 0, {MINV, MINV, MINV}, Z3, {MAXV, MAXV, MAXV}, Z3);
        add_row(1, 1, {MAXV, MAXV, MAXV}, {MAXV, MAXV, MAXV},
                {MAXV, MAXV, MAXV}, {MAXV, MAXV, MAXV});
        add_row(1, 1, {MINV, MINV, MINV}, {MINV, MINV, MINV},
                {MINV, MINV, MINV}, {MINV, MINV, MINV});
        add_row(1, 0, Z3, Z3, {32'd0, 32'd0, 32'd66847}, Z3);
        add_row(1, 0, Z3, Z3, {32'd0, 32'd0, -32'sd66847}, Z3);
        add_row(0, 0, Z3, Z3, {32'd0, 32'd0, 32'd66846}, Z3);
        add_row(0, 0, Z3, {32'd0, 32'd0, 32'd1000}, Z3, Z3);
        add_row(0, 0, Z3, Z3, {32'd0, 32'd0, 32'd32768}, Z3);
        add_row(0, 0, Z3, Z3, {32'd0, 32'd32768, 32'd0}, Z3);
        add_row(0, 0, Z3, Z3, {-32'sd32768, 32'd0, 32'd0}, Z3);
        add_row(0, 0, {32'd5, 32'd5, 32'd5}, {32'd9000, -32'sd700, 32'd0},
                {32'd20000, 32'd20000, 32'd20000}, {32'd0, 32'd3000, -32'sd4000});
        add_row(0, 0, {MAXV, MAXV, MAXV}, {MINV, MINV, MINV},
                {MAXV, MAXV, MAXV - 32'd100}, {MINV, MAXV, MINV});
        add_row(0, 0, Z3, {MAXV, MINV, MAXV}, {32'd10, 32'd10, 32'd10},
                {MINV, MAXV, MINV});
        foreach (dir_pairs[i]) send_pair(dir_pairs[i], dir_q[i]);

        drain();
        cfg_write(CFG_SFRIC, 31'd65536);
        cfg_write(CFG_KFRIC, 31'd30000);
        foreach (dir_pairs[i])
            if (!dir_q[i].known) send_pair(dir_pairs[i], '{1'b0, dir_q[i].corr});

        random_phase(180, 65536, 66847, 65536, 30000);
        fork
            begin
                repeat (30) @(posedge i_clk);
                hold_go = 1'b1;
            end
        join_none
        random_phase(200, 131071, 1048576, 65536, 65536);
        random_phase(120, 0, 0, 0, 0);
        random_phase(180, 65536, 2147483647, 131071, 131071);
        random_phase(180, 32768, 300000, $urandom_range(131071), $urandom_range(131071));
        quiet = 1'b1;
        random_phase(160, 65536, 5000, 65536, 20000);
        quiet = 1'b0;
        random_phase(100, 90000, 2000000, 1000, 131071);

        s_axis_tvalid <= 1'b0;
        wait (corr_q.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && corr_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
